// ===== rtl/spa_pkg.sv =====
package spa_pkg;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CntW     = $clog2(NumSlots + 1);
  localparam int unsigned CfgW     = 7;

  localparam logic [1:0] ReqAlloc   = 2'd0;
  localparam logic [1:0] ReqRelease = 2'd1;

  localparam logic [2:0] StatDone     = 3'd0;
  localparam logic [2:0] StatEmpty    = 3'd1;
  localparam logic [2:0] StatQuota    = 3'd2;
  localparam logic [2:0] StatAlready  = 3'd3;
  localparam logic [2:0] StatShutdown = 3'd4;

  localparam logic CfgMaxIncoming = 1'b0;
  localparam logic CfgShutdown    = 1'b1;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             is_incoming;
    logic [SlotW-1:0] slot_in;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SlotW-1:0] slot_out;
    logic             freed_notice;
    logic [CntW-1:0]  outgoing_count;
  } rsp_t;

endpackage

// ===== rtl/spa_ram.sv =====
module spa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/slot_pool_allocator_with_quota.sv =====
// Slot pool with a last-in-first-out free stack and a quota on incoming slots. Each request
// beat first reads the stack top and the slot's state from their single-port-read memories,
// then decides, writes back and loads the result register. The block takes the next beat as
// soon as it is back in its idle cycle, even while a result waits to be taken; it holds the
// decide cycle only while the result register is full and stalled. No clearing pass follows
// reset: per-entry written bits make unwritten entries read as their reset values.
module slot_pool_allocator_with_quota (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [spa_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  spa_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output spa_pkg::rsp_t                 out_data_o
);

  localparam int unsigned SlotW = spa_pkg::SlotW;
  localparam int unsigned CntW  = spa_pkg::CntW;
  localparam logic [CntW-1:0] FullDepth = CntW'(spa_pkg::NumSlots);

  spa_pkg::state_e state_q, state_d;
  spa_pkg::req_t   req_q;
  logic [CntW-1:0] depth_q, depth_d;
  logic [CntW-1:0] inc_cnt_q, inc_cnt_d;
  logic [CntW-1:0] max_inc_q;
  logic            shutdown_q;
  logic [spa_pkg::NumSlots-1:0] stk_vld_q;
  logic [spa_pkg::NumSlots-1:0] sst_vld_q;
  logic            stk_sel_vld_q;
  logic            sst_sel_vld_q;
  logic [SlotW-1:0] stk_raddr_q;
  logic            out_valid_q;
  spa_pkg::rsp_t   out_data_q, rsp_d;

  logic            in_acc;
  logic            exec_go;
  logic [SlotW-1:0] stk_raddr;
  logic [SlotW-1:0] stk_rdata;
  logic [1:0]      sst_rdata;
  logic [SlotW-1:0] pop_slot;
  logic            sel_used;
  logic            sel_inc;
  logic            stk_we;
  logic [SlotW-1:0] stk_waddr;
  logic            sst_we;
  logic [SlotW-1:0] sst_waddr;
  logic [1:0]      sst_wdata;
  logic [CntW-1:0] used_cnt;

  assign in_stall_o = (state_q != spa_pkg::StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign exec_go    = (state_q == spa_pkg::StExec) && (!out_valid_q || !out_stall_i);
  assign stk_raddr  = SlotW'(depth_q - CntW'(1));

  spa_ram #(
    .Width (SlotW),
    .Depth (spa_pkg::NumSlots)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (req_q.slot_in),
    .re_i    (in_acc),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  spa_ram #(
    .Width (2),
    .Depth (spa_pkg::NumSlots)
  ) u_slot_state (
    .clk_i   (clk_i),
    .we_i    (sst_we),
    .waddr_i (sst_waddr),
    .wdata_i (sst_wdata),
    .re_i    (in_acc),
    .raddr_i (in_data_i.slot_in),
    .rdata_o (sst_rdata)
  );

  assign pop_slot = stk_sel_vld_q ? stk_rdata : stk_raddr_q;
  assign sel_used = sst_sel_vld_q && sst_rdata[1];
  assign sel_inc  = sst_sel_vld_q && sst_rdata[0];

  always_comb begin
    depth_d   = depth_q;
    inc_cnt_d = inc_cnt_q;
    stk_we    = 1'b0;
    stk_waddr = depth_q[SlotW-1:0];
    sst_we    = 1'b0;
    sst_waddr = req_q.slot_in;
    sst_wdata = 2'b00;
    rsp_d     = '0;
    rsp_d.status = spa_pkg::StatDone;
    unique case (req_q.req_type)
      spa_pkg::ReqAlloc: begin
        if (depth_q == '0) begin
          rsp_d.status = spa_pkg::StatEmpty;
        end else if (req_q.is_incoming && (inc_cnt_q >= max_inc_q)) begin
          rsp_d.status = spa_pkg::StatQuota;
        end else begin
          if (req_q.is_incoming) begin
            inc_cnt_d = inc_cnt_q + CntW'(1);
          end
          depth_d        = depth_q - CntW'(1);
          sst_we         = exec_go;
          sst_waddr      = pop_slot;
          sst_wdata      = {1'b1, req_q.is_incoming};
          rsp_d.slot_out = pop_slot;
        end
      end
      spa_pkg::ReqRelease: begin
        if (shutdown_q) begin
          rsp_d.status = spa_pkg::StatShutdown;
        end else if (!sel_used || (depth_q >= FullDepth)) begin
          rsp_d.status = spa_pkg::StatAlready;
        end else begin
          sst_we  = exec_go;
          stk_we  = exec_go;
          depth_d = depth_q + CntW'(1);
          if (sel_inc && (inc_cnt_q != '0)) begin
            inc_cnt_d = inc_cnt_q - CntW'(1);
          end
          rsp_d.freed_notice = 1'b1;
        end
      end
      default: begin
      end
    endcase
    used_cnt = FullDepth - depth_d;
    rsp_d.outgoing_count = (used_cnt >= inc_cnt_d) ? used_cnt - inc_cnt_d : '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spa_pkg::StIdle: begin
        if (in_acc) begin
          state_d = spa_pkg::StExec;
        end
      end
      spa_pkg::StExec: begin
        if (exec_go) begin
          state_d = spa_pkg::StIdle;
        end
      end
      default: state_d = spa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spa_pkg::StIdle;
      depth_q     <= FullDepth;
      inc_cnt_q   <= '0;
      max_inc_q   <= CntW'(spa_pkg::NumSlots);
      shutdown_q  <= 1'b0;
      stk_vld_q   <= '0;
      sst_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          spa_pkg::CfgMaxIncoming: max_inc_q  <= cfg_wdata_i;
          spa_pkg::CfgShutdown:    shutdown_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (exec_go) begin
        depth_q     <= depth_d;
        inc_cnt_q   <= inc_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (stk_we) begin
        stk_vld_q[stk_waddr] <= 1'b1;
      end
      if (sst_we) begin
        sst_vld_q[sst_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q         <= in_data_i;
      stk_raddr_q   <= stk_raddr;
      stk_sel_vld_q <= stk_vld_q[stk_raddr];
      sst_sel_vld_q <= sst_vld_q[in_data_i.slot_in];
    end
    if (exec_go) begin
      out_data_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= FullDepth)
    else $error("free stack depth beyond pool size");

  a_inc_within_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inc_cnt_q <= FullDepth - depth_q)
    else $error("incoming count exceeds slots in use");

  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && (req_q.req_type == spa_pkg::ReqAlloc) && (rsp_d.status == spa_pkg::StatDone)
    |=> depth_q == $past(depth_q) - CntW'(1))
    else $error("successful allocate did not pop one entry");

  a_freed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.freed_notice |-> out_data_o.status == spa_pkg::StatDone)
    else $error("freed notice on a failed beat");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

class pool_ledger;
  logic [spa_pkg::SlotW-1:0] free_stack [spa_pkg::NumSlots];
  int unsigned               depth;
  bit                        slot_free [spa_pkg::NumSlots];
  bit                        slot_inc [spa_pkg::NumSlots];
  int unsigned               inc_used;
  logic [spa_pkg::CfgW-1:0]  max_inc;
  bit                        shutdown;
  spa_pkg::rsp_t             awaited [$];
  int unsigned               mismatches;

  function new();
    for (int i = 0; i < spa_pkg::NumSlots; i++) begin
      free_stack[i] = spa_pkg::SlotW'(i);
      slot_free[i]  = 1'b1;
      slot_inc[i]   = 1'b0;
    end
    depth      = spa_pkg::NumSlots;
    inc_used   = 0;
    max_inc    = spa_pkg::CfgW'(spa_pkg::NumSlots);
    shutdown   = 1'b0;
    mismatches = 0;
  endfunction

  function void write_reg(logic idx, logic [spa_pkg::CfgW-1:0] val);
    if (idx == spa_pkg::CfgMaxIncoming) begin
      max_inc = val;
    end else begin
      shutdown = val[0];
    end
  endfunction

  function void note_request(spa_pkg::req_t r);
    spa_pkg::rsp_t             exp_r;
    logic [spa_pkg::SlotW-1:0] s;
    int unsigned               used;
    exp_r        = '0;
    exp_r.status = spa_pkg::StatDone;
    if (r.req_type == spa_pkg::ReqAlloc) begin
      if (depth == 0) begin
        exp_r.status = spa_pkg::StatEmpty;
      end else if (r.is_incoming && inc_used >= max_inc) begin
        exp_r.status = spa_pkg::StatQuota;
      end else begin
        if (r.is_incoming) inc_used++;
        depth--;
        s              = free_stack[depth];
        slot_free[s]   = 1'b0;
        slot_inc[s]    = r.is_incoming;
        exp_r.slot_out = s;
      end
    end else if (r.req_type == spa_pkg::ReqRelease) begin
      if (shutdown) begin
        exp_r.status = spa_pkg::StatShutdown;
      end else if (slot_free[r.slot_in] || depth >= spa_pkg::NumSlots) begin
        exp_r.status = spa_pkg::StatAlready;
      end else begin
        slot_free[r.slot_in] = 1'b1;
        free_stack[depth]    = r.slot_in;
        depth++;
        if (slot_inc[r.slot_in] && inc_used > 0) inc_used--;
        exp_r.freed_notice = 1'b1;
      end
    end
    used = spa_pkg::NumSlots - depth;
    exp_r.outgoing_count = (used >= inc_used) ? spa_pkg::CntW'(used - inc_used) : '0;
    awaited = {awaited, exp_r};
  endfunction

  function void check_reply(spa_pkg::rsp_t got);
    spa_pkg::rsp_t exp_r;
    if (awaited.size() == 0) begin
      $error("unexpected result beat: %h", got);
      mismatches++;
      return;
    end
    exp_r = awaited.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      mismatches++;
    end
    if (got.slot_out !== exp_r.slot_out) begin
      $error("slot_out: expected %0d, got %0d", exp_r.slot_out, got.slot_out);
      mismatches++;
    end
    if (got.freed_notice !== exp_r.freed_notice) begin
      $error("freed_notice: expected %0d, got %0d", exp_r.freed_notice, got.freed_notice);
      mismatches++;
    end
    if (got.outgoing_count !== exp_r.outgoing_count) begin
      $error("outgoing_count: expected %0d, got %0d", exp_r.outgoing_count,
             got.outgoing_count);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0]  ReqQuery    = 2'd2;
  localparam logic [1:0]  ReqSpare    = 2'd3;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 8;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_idx_i;
  logic [spa_pkg::CfgW-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  spa_pkg::req_t            in_data_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  spa_pkg::rsp_t            out_data_o;

  pool_ledger  ledger;
  int unsigned idle_pct = 22;
  int unsigned hold_ask = 0;
  int unsigned quiet_cycles;

  slot_pool_allocator_with_quota u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) ledger.check_reply(out_data_o);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  function automatic spa_pkg::req_t beat(logic [1:0] kind, logic inc,
                                         logic [spa_pkg::SlotW-1:0] slot);
    spa_pkg::req_t r;
    r.req_type    = kind;
    r.is_incoming = inc;
    r.slot_in     = slot;
    return r;
  endfunction

  function automatic spa_pkg::req_t pick_request(int unsigned alloc_pct);
    spa_pkg::req_t             r;
    int unsigned               roll;
    logic [spa_pkg::SlotW-1:0] held [$];
    r    = beat(spa_pkg::ReqAlloc, 1'($urandom_range(1)),
                spa_pkg::SlotW'($urandom_range(spa_pkg::NumSlots - 1)));
    roll = $urandom_range(99);
    if (roll < 10) begin
      r.req_type = 2'($urandom_range(3));
    end else if (roll >= 10 + alloc_pct * 90 / 100) begin
      for (int i = 0; i < spa_pkg::NumSlots; i++) begin
        if (!ledger.slot_free[i]) held = {held, spa_pkg::SlotW'(i)};
      end
      if (held.size() != 0) begin
        r.req_type = spa_pkg::ReqRelease;
        r.slot_in  = held[$urandom_range(held.size() - 1)];
      end
    end
    return r;
  endfunction

  task automatic send_beat(input spa_pkg::req_t r);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(r);
  endtask

  task automatic set_register(input logic idx, input logic [spa_pkg::CfgW-1:0] val);
    in_valid_i <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned alloc_pct,
                           input logic [spa_pkg::CfgW-1:0] quota, input logic shut,
                           input bit calm, input bit press);
    set_register(spa_pkg::CfgMaxIncoming, quota);
    set_register(spa_pkg::CfgShutdown, spa_pkg::CfgW'(shut));
    idle_pct = calm ? 0 : 22;
    if (press) hold_ask++;
    repeat (n) send_beat(pick_request(alloc_pct));
  endtask

  initial begin
    ledger      = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = spa_pkg::CfgMaxIncoming;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(beat(ReqQuery, 1'b1, 6'd63));
    send_beat(beat(ReqSpare, 1'b1, 6'h2a));
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd0));
    send_beat(beat(spa_pkg::ReqAlloc, 1'b0, 6'd0));
    send_beat(beat(spa_pkg::ReqAlloc, 1'b1, 6'd63));
    send_beat(beat(spa_pkg::ReqAlloc, 1'b1, 6'd0));
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd62));
    send_beat(beat(spa_pkg::ReqRelease, 1'b1, 6'd62));
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd63));
    set_register(spa_pkg::CfgMaxIncoming, 7'd1);
    send_beat(beat(spa_pkg::ReqAlloc, 1'b1, 6'd0));
    send_beat(beat(spa_pkg::ReqAlloc, 1'b0, 6'd0));
    set_register(spa_pkg::CfgMaxIncoming, 7'd0);
    send_beat(beat(spa_pkg::ReqAlloc, 1'b1, 6'd63));
    set_register(spa_pkg::CfgShutdown, 7'd1);
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd63));
    send_beat(beat(spa_pkg::ReqRelease, 1'b1, 6'd5));
    set_register(spa_pkg::CfgShutdown, 7'd0);
    set_register(spa_pkg::CfgMaxIncoming, 7'd64);
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd61));
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd63));
    send_beat(beat(spa_pkg::ReqRelease, 1'b0, 6'd63));

    run_phase(140, 50, 7'd64, 1'b0, 1'b0, 1'b0);
    run_phase(150, 85, 7'd64, 1'b0, 1'b0, 1'b1);
    run_phase(140, 30, 7'd3, 1'b0, 1'b0, 1'b0);
    run_phase(50, 50, 7'd0, 1'b1, 1'b0, 1'b0);
    run_phase(230, 55, 7'd64, 1'b0, 1'b1, 1'b0);
    run_phase(140, 80, 7'd1, 1'b0, 1'b0, 1'b0);
    run_phase(140, 50, 7'($urandom_range(63, 2)), 1'b0, 1'b0, 1'b0);
    run_phase(100, 20, 7'd64, 1'b0, 1'b0, 1'b0);
    run_phase(140, 90, 7'd0, 1'b0, 1'b0, 1'b0);
    run_phase(70, 50, 7'd64, 1'b1, 1'b0, 1'b1);
    run_phase(80, 60, 7'd64, 1'b0, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
